FILE: hw/rtl/eci_pkg.sv
// eci_pkg: widths, codes and request types shared by the easing curve interpolator.
// Depends on nothing; every other file of the block uses it by scoped names.
`default_nettype none
package eci_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int ONE           = 1 << FRACTION_BITS;

    localparam int TW  = FRACTION_BITS + 1;   // progress
    localparam int CW  = FRACTION_BITS + 2;   // Q2.F ease and config
    localparam int MW  = FRACTION_BITS + 4;   // curve multiplier operands
    localparam int PW  = 2 * MW;
    localparam int UPW = 2 * TW;
    localparam int EW  = FRACTION_BITS + 8;   // ease before saturation
    localparam int BW  = TW + 1 + CW;         // bezier weight products
    localparam int SW  = VALUE_WIDTH + 1;     // span
    localparam int PHW = SW - FRACTION_BITS + CW;
    localparam int PLW = FRACTION_BITS + 1 + CW;
    localparam int RW  = VALUE_WIDTH + 4;

    localparam longint VMAX = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPW         = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        OP_LINEAR      = 3'd0,
        OP_EASE_IN     = 3'd1,
        OP_EASE_OUT    = 3'd2,
        OP_EASE_IN_OUT = 3'd3,
        OP_BOUNCE      = 3'd4,
        OP_BEZIER      = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        SHIFT_F,
        SHIFT_F4,
        SHIFT_F6
    } shift_t;

    typedef enum logic {
        REG_BEZIER_FIRST_Y  = 1'b0,
        REG_BEZIER_SECOND_Y = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic                          bez;
        shift_t                        shift;
        logic signed [MW-1:0]          m1a;
        logic signed [MW-1:0]          m1b;
        logic signed [MW-1:0]          m2;
        logic signed [CW-1:0]          c;
        logic [TW-1:0]                 t;
        logic signed [VALUE_WIDTH-1:0] start;
        logic signed [VALUE_WIDTH-1:0] fin;
    } item_t;

endpackage
`default_nettype wire

FILE: hw/rtl/eci_front.sv
// eci_front: clamps progress and classifies each request into multiplier operands.
// Depends on eci_pkg.
`default_nettype none
module eci_front (
    input  wire logic [2:0]                           op,
    input  wire logic signed [eci_pkg::VALUE_WIDTH-1:0] start_value,
    input  wire logic signed [eci_pkg::VALUE_WIDTH-1:0] end_value,
    input  wire logic [eci_pkg::TW-1:0]               progress,
    output eci_pkg::item_t                            item
);

    localparam int MW = eci_pkg::MW;
    localparam int ONE = eci_pkg::ONE;

    logic [eci_pkg::TW-1:0]  t_c;
    logic signed [MW-1:0]    ts;
    logic signed [MW-1:0]    one_s;
    logic signed [MW-1:0]    f;
    logic signed [MW+1:0]    tw;
    logic signed [MW+1:0]    t11;

    always_comb
    begin
        t_c   = (progress > eci_pkg::TW'(ONE)) ? eci_pkg::TW'(ONE) : progress;
        tw    = (MW+2)'(t_c);
        ts    = MW'(tw);
        one_s = MW'(ONE);
        f     = ts - one_s;
        t11   = (tw <<< 3) + (tw <<< 1) + tw;

        item.bez   = 1'b0;
        item.shift = eci_pkg::SHIFT_F;
        item.m1a   = ts;
        item.m1b   = one_s;
        item.m2    = one_s;
        item.c     = '0;
        item.t     = t_c;
        item.start = start_value;
        item.fin   = end_value;

        case (eci_pkg::op_t'(op))
            eci_pkg::OP_EASE_IN:
            begin
                item.m1b = ts;
                item.m2  = ts;
            end
            eci_pkg::OP_EASE_OUT:
            begin
                item.m1a = f;
                item.m1b = f;
                item.m2  = f;
                item.c   = eci_pkg::CW'(ONE);
            end
            eci_pkg::OP_EASE_IN_OUT:
            begin
                if (t_c < eci_pkg::TW'(ONE / 2))
                begin
                    item.m1a = ts <<< 2;
                    item.m1b = ts;
                    item.m2  = ts;
                end
                else
                begin
                    item.m1a = f;
                    item.m1b = f <<< 1;
                    item.m2  = f <<< 1;
                    item.c   = eci_pkg::CW'(ONE);
                end
            end
            eci_pkg::OP_BOUNCE:
            begin
                item.shift = eci_pkg::SHIFT_F4;
                if (t11 < (MW+2)'(4 * ONE))
                begin
                    item.m1a = MW'(t11);
                end
                else if (t11 < (MW+2)'(8 * ONE))
                begin
                    item.m1a = MW'(t11 - (MW+2)'(6 * ONE));
                    item.c   = eci_pkg::CW'((3 * ONE) / 4);
                end
                else if (t11 < (MW+2)'(10 * ONE))
                begin
                    item.m1a = MW'(t11 - (MW+2)'(9 * ONE));
                    item.c   = eci_pkg::CW'((15 * ONE) / 16);
                end
                else
                begin
                    item.shift = eci_pkg::SHIFT_F6;
                    item.m1a   = MW'((t11 <<< 1) - (MW+2)'(21 * ONE));
                    item.c     = eci_pkg::CW'((63 * ONE) / 64);
                end
                item.m1b = item.m1a;
            end
            eci_pkg::OP_BEZIER:
            begin
                item.bez = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/eci_queue.sv
// eci_queue: short register queue of classified requests between front and back.
// Depends on eci_pkg.
`default_nettype none
module eci_queue (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire eci_pkg::item_t din,
    output logic          full,
    input  wire logic     pop,
    output logic          empty,
    output eci_pkg::item_t dout
);

    localparam int QD  = eci_pkg::QUEUE_DEPTH;
    localparam int QPW = eci_pkg::QPW;

    eci_pkg::item_t   mem_reg [QD];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPW:0]     count_reg, count_next;
    logic             wr_en, rd_en;

    assign full  = (count_reg == (QPW+1)'(QD));
    assign empty = (count_reg == '0);
    assign wr_en = push && !full;
    assign rd_en = pop && !empty;
    assign dout  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_en ? QPW'((QPW+1)'(wr_ptr_reg) + 1'b1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? QPW'((QPW+1)'(rd_ptr_reg) + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + (QPW+1)'(wr_en) - (QPW+1)'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/eci_back.sv
// eci_back: six-stage multiply pipeline for ease factor and interpolation.
// Depends on eci_pkg; the whole pipeline holds while its last result waits.
`default_nettype none
module eci_back (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire eci_pkg::item_t                        q_item,
    input  wire logic                                  q_empty,
    output logic                                       q_pop,
    input  wire logic signed [eci_pkg::CW-1:0]         y1,
    input  wire logic signed [eci_pkg::CW-1:0]         y2,
    input  wire logic                                  pop,
    output logic                                       empty,
    output logic signed [eci_pkg::VALUE_WIDTH-1:0]     interpolated,
    output logic                                       clipped
);

    localparam int FB  = eci_pkg::FRACTION_BITS;
    localparam int TW  = eci_pkg::TW;
    localparam int CW  = eci_pkg::CW;
    localparam int MW  = eci_pkg::MW;
    localparam int PW  = eci_pkg::PW;
    localparam int UPW = eci_pkg::UPW;
    localparam int EW  = eci_pkg::EW;
    localparam int BW  = eci_pkg::BW;
    localparam int SW  = eci_pkg::SW;
    localparam int PHW = eci_pkg::PHW;
    localparam int PLW = eci_pkg::PLW;
    localparam int RW  = eci_pkg::RW;
    localparam int VW  = eci_pkg::VALUE_WIDTH;
    localparam int ONE = eci_pkg::ONE;

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;

    // stage 1
    logic signed [PW-1:0]  p1_reg, p1_next;
    logic [UPW-1:0]        uu1_reg, uu1_next, tt1_reg, tt1_next;
    logic [TW-1:0]         t1_reg, u1_reg, u1_next;
    eci_pkg::shift_t       sh1_reg;
    logic signed [MW-1:0]  m21_reg;
    logic signed [CW-1:0]  c1_reg;
    logic                  bez1_reg;
    logic signed [SW-1:0]  span1_reg, span1_next;
    logic signed [VW-1:0]  st1_reg;

    // stage 2
    logic signed [MW-1:0]  a1;
    logic [TW-1:0]         uu, tt;
    logic signed [PW-1:0]  q2_reg, q2_next;
    logic [UPW-1:0]        ba2_reg, ba2_next, bb2_reg, bb2_next, bc2_reg, bc2_next;
    logic signed [CW-1:0]  c2_reg;
    logic                  bez2_reg;
    logic signed [SW-1:0]  span2_reg;
    logic signed [VW-1:0]  st2_reg;

    // stage 3
    logic signed [EW-1:0]  eg3_reg, eg3_next;
    logic signed [BW-1:0]  bd3_reg, bd3_next, be3_reg, be3_next;
    logic [TW-1:0]         bc3_reg;
    logic                  bez3_reg;
    logic signed [SW-1:0]  span3_reg;
    logic signed [VW-1:0]  st3_reg;

    // stage 4
    logic signed [EW-1:0]  bdx, bex, bcx, er;
    logic signed [CW-1:0]  e4_reg, e4_next;
    logic signed [SW-1:0]  span4_reg;
    logic signed [VW-1:0]  st4_reg;

    // stage 5
    logic signed [PHW-1:0] ph5_reg, ph5_next;
    logic signed [PLW-1:0] pl5_reg, pl5_next;
    logic signed [VW-1:0]  st5_reg;

    // stage 6
    logic signed [RW-1:0]  res;
    logic signed [VW-1:0]  out_reg, out_next;
    logic                  clip_reg, clip_next;

    assign adv   = !v6_reg || pop;
    assign q_pop = adv && !q_empty;
    assign empty = !v6_reg;
    assign interpolated = out_reg;
    assign clipped      = clip_reg;

    always_comb
    begin
        p1_next    = q_item.m1a * q_item.m1b;
        u1_next    = TW'(ONE) - q_item.t;
        uu1_next   = UPW'(u1_next) * UPW'(u1_next);
        tt1_next   = UPW'(q_item.t) * UPW'(q_item.t);
        span1_next = SW'(q_item.fin) - SW'(q_item.start);

        case (sh1_reg)
            eci_pkg::SHIFT_F4: a1 = MW'(p1_reg >>> (FB + 4));
            eci_pkg::SHIFT_F6: a1 = MW'(p1_reg >>> (FB + 6));
            default:           a1 = MW'(p1_reg >>> FB);
        endcase
        q2_next  = a1 * m21_reg;
        uu       = TW'(uu1_reg >> FB);
        tt       = TW'(tt1_reg >> FB);
        ba2_next = UPW'(uu) * UPW'(t1_reg);
        bb2_next = UPW'(u1_reg) * UPW'(tt);
        bc2_next = UPW'(tt) * UPW'(t1_reg);

        eg3_next = EW'(q2_reg >>> FB) + EW'(c2_reg);
        bd3_next = $signed({1'b0, ba2_reg[FB+TW-1:FB]}) * y1;
        be3_next = $signed({1'b0, bb2_reg[FB+TW-1:FB]}) * y2;

        bdx = EW'(bd3_reg >>> FB);
        bex = EW'(be3_reg >>> FB);
        bcx = EW'(bc3_reg);
        er  = bez3_reg ? ((bdx <<< 1) + bdx + (bex <<< 1) + bex + bcx) : eg3_reg;
        if (er > EW'(2 * ONE - 1))
            e4_next = CW'(2 * ONE - 1);
        else if (er < EW'(-2 * ONE))
            e4_next = CW'(-2 * ONE);
        else
            e4_next = CW'(er);

        ph5_next = $signed(span4_reg[SW-1:FB]) * e4_reg;
        pl5_next = $signed({1'b0, span4_reg[FB-1:0]}) * e4_reg;

        res = RW'(st5_reg) + RW'(ph5_reg) + RW'(pl5_reg >>> FB);
        clip_next = 1'b0;
        if (res > RW'(eci_pkg::VMAX))
        begin
            out_next  = VW'(eci_pkg::VMAX);
            clip_next = 1'b1;
        end
        else if (res < RW'(eci_pkg::VMIN))
        begin
            out_next  = VW'(eci_pkg::VMIN);
            clip_next = 1'b1;
        end
        else
        begin
            out_next = VW'(res);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= !q_empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_reg    <= p1_next;
            uu1_reg   <= uu1_next;
            tt1_reg   <= tt1_next;
            t1_reg    <= q_item.t;
            u1_reg    <= u1_next;
            sh1_reg   <= q_item.shift;
            m21_reg   <= q_item.m2;
            c1_reg    <= q_item.c;
            bez1_reg  <= q_item.bez;
            span1_reg <= span1_next;
            st1_reg   <= q_item.start;

            q2_reg    <= q2_next;
            ba2_reg   <= ba2_next;
            bb2_reg   <= bb2_next;
            bc2_reg   <= bc2_next;
            c2_reg    <= c1_reg;
            bez2_reg  <= bez1_reg;
            span2_reg <= span1_reg;
            st2_reg   <= st1_reg;

            eg3_reg   <= eg3_next;
            bd3_reg   <= bd3_next;
            be3_reg   <= be3_next;
            bc3_reg   <= bc2_reg[FB+TW-1:FB];
            bez3_reg  <= bez2_reg;
            span3_reg <= span2_reg;
            st3_reg   <= st2_reg;

            e4_reg    <= e4_next;
            span4_reg <= span3_reg;
            st4_reg   <= st3_reg;

            ph5_reg   <= ph5_next;
            pl5_reg   <= pl5_next;
            st5_reg   <= st4_reg;

            out_reg   <= out_next;
            clip_reg  <= clip_next;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/easing_curve_interpolator_top.sv
// easing_curve_interpolator_top: request front, queue, multiply back end and config.
// Depends on eci_pkg, eci_front, eci_queue and eci_back.
`default_nettype none
// Takes one request per cycle while not full and returns one result per cycle while
// results are popped, in order. A request accepted into an empty block is taken by the
// back end from the four-entry request queue at the next edge, and it then passes the
// six-stage multiply pipeline (curve products, Bezier weights, saturation, span
// product, sum and clip). The pipeline holds as a whole while a result waits; the
// queue keeps accepting until it fills. Bezier control heights are written through
// the config port; the user must write them only while idle, the block does not enforce it.
module easing_curve_interpolator_top (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   push,
    output logic                                        full,
    input  wire logic [2:0]                             op,
    input  wire logic signed [eci_pkg::VALUE_WIDTH-1:0] start_value,
    input  wire logic signed [eci_pkg::VALUE_WIDTH-1:0] end_value,
    input  wire logic [eci_pkg::TW-1:0]                 progress,
    output logic                                        empty,
    input  wire logic                                   pop,
    output logic signed [eci_pkg::VALUE_WIDTH-1:0]      interpolated,
    output logic                                        clipped,
    input  wire logic                                   cfg_write,
    input  wire logic                                   cfg_index,
    input  wire logic [eci_pkg::CW-1:0]                 cfg_data
);

    eci_pkg::item_t                  f_item, q_item;
    logic                            q_empty, q_pop;
    logic signed [eci_pkg::CW-1:0]   y1_reg, y1_next, y2_reg, y2_next;

    always_comb
    begin
        y1_next = y1_reg;
        y2_next = y2_reg;
        if (cfg_write)
        begin
            unique case (eci_pkg::cfg_reg_t'(cfg_index))
                eci_pkg::REG_BEZIER_FIRST_Y:  y1_next = cfg_data;
                eci_pkg::REG_BEZIER_SECOND_Y: y2_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y1_reg <= '0;
            y2_reg <= eci_pkg::CW'(eci_pkg::ONE);
        end
        else
        begin
            y1_reg <= y1_next;
            y2_reg <= y2_next;
        end
    end

    eci_front u_front (
        .op          (op),
        .start_value (start_value),
        .end_value   (end_value),
        .progress    (progress),
        .item        (f_item)
    );

    eci_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (f_item),
        .full  (full),
        .pop   (q_pop),
        .empty (q_empty),
        .dout  (q_item)
    );

    eci_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_item       (q_item),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .y1           (y1_reg),
        .y2           (y2_reg),
        .pop          (pop),
        .empty        (empty),
        .interpolated (interpolated),
        .clipped      (clipped)
    );

`ifndef SYNTHESIS
    a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && clipped) |->
            (interpolated == eci_pkg::VALUE_WIDTH'(eci_pkg::VMAX)) ||
            (interpolated == eci_pkg::VALUE_WIDTH'(eci_pkg::VMIN)))
        else $error("clipped result not at a limit");

    a_drain_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (!q_empty && empty) |-> q_pop)
        else $error("queued request not taken by idle back end");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !q_empty)
        else $error("queue full and empty at once");
`endif

endmodule
`default_nettype wire

FILE: test/tb_easing_curve_interpolator_top.sv
// Self-checking bench for easing_curve_interpolator_top: random and directed keyframe
// requests checked against an in-bench fixed point easing predictor.
// Depends on eci_pkg and the easing_curve_interpolator_top RTL.
`timescale 1ns / 100ps

module tb_easing_curve_interpolator_top;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] start_v;
        logic signed [31:0] end_v;
        logic [16:0]        prog;
    } request_t;

    typedef struct {
        logic signed [31:0] value;
        logic               clip;
    } outcome_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    logic               full;
    logic [2:0]         op;
    logic signed [31:0] start_value;
    logic signed [31:0] end_value;
    logic [16:0]        progress;
    logic               empty;
    logic               pop;
    logic signed [31:0] interpolated;
    logic               clipped;
    logic               cfg_write;
    logic               cfg_index;
    logic [17:0]        cfg_data;

    request_t pending_requests[$];
    outcome_t expected_outcomes[$];
    longint   ctrl_first_y;
    longint   ctrl_second_y;
    int       mismatches;
    int       push_gap;
    int       pop_stall;

    easing_curve_interpolator_top uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .op(op),
        .start_value(start_value), .end_value(end_value), .progress(progress),
        .empty(empty), .pop(pop), .interpolated(interpolated), .clipped(clipped),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> eci_pkg::FRACTION_BITS;
    endfunction

    function automatic longint ease_factor(logic [2:0] sel, longint t);
        longint e;
        longint f;
        longint u;
        longint uu;
        longint tt;
        longint one;
        one = eci_pkg::ONE;
        case (sel)
            eci_pkg::OP_EASE_IN:
                e = qmul(qmul(t, t), t);
            eci_pkg::OP_EASE_OUT:
            begin
                f = t - one;
                e = qmul(qmul(f, f), f) + one;
            end
            eci_pkg::OP_EASE_IN_OUT:
            begin
                if (2 * t < one)
                    e = qmul(qmul(4 * t, t), t);
                else
                begin
                    f = t - one;
                    e = qmul(qmul(f, 2 * f), 2 * f) + one;
                end
            end
            eci_pkg::OP_BOUNCE:
            begin
                if (11 * t < 4 * one)
                    e = (11 * t * 11 * t) >>> (eci_pkg::FRACTION_BITS + 4);
                else if (11 * t < 8 * one)
                begin
                    u = 11 * t - 6 * one;
                    e = ((u * u) >>> (eci_pkg::FRACTION_BITS + 4)) + (3 * one) / 4;
                end
                else if (11 * t < 10 * one)
                begin
                    u = 11 * t - 9 * one;
                    e = ((u * u) >>> (eci_pkg::FRACTION_BITS + 4)) + (15 * one) / 16;
                end
                else
                begin
                    u = 22 * t - 21 * one;
                    e = ((u * u) >>> (eci_pkg::FRACTION_BITS + 6)) + (63 * one) / 64;
                end
            end
            eci_pkg::OP_BEZIER:
            begin
                u  = one - t;
                uu = qmul(u, u);
                tt = qmul(t, t);
                e  = 3 * qmul(qmul(uu, t), ctrl_first_y)
                   + 3 * qmul(qmul(u, tt), ctrl_second_y) + qmul(tt, t);
            end
            default:
                e = t;
        endcase
        if (e > 2 * one - 1)
            e = 2 * one - 1;
        if (e < -2 * one)
            e = -2 * one;
        return e;
    endfunction

    function automatic outcome_t interpolate(request_t r);
        outcome_t o;
        longint   t;
        longint   res;
        t = r.prog;
        if (t > eci_pkg::ONE)
            t = eci_pkg::ONE;
        res = longint'(r.start_v)
            + (((longint'(r.end_v) - longint'(r.start_v)) * ease_factor(r.op, t))
               >>> eci_pkg::FRACTION_BITS);
        o.clip = 1'b0;
        if (res > eci_pkg::VMAX)
        begin
            res    = eci_pkg::VMAX;
            o.clip = 1'b1;
        end
        else if (res < eci_pkg::VMIN)
        begin
            res    = eci_pkg::VMIN;
            o.clip = 1'b1;
        end
        o.value = res[31:0];
        return o;
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        logic taken;
        logic next_push;
        if (!rst_n)
        begin
            push     <= 1'b0;
            push_gap <= 0;
        end
        else
        begin
            taken     = push && !full;
            next_push = push;
            if (taken)
            begin
                expected_outcomes.push_back(interpolate(pending_requests.pop_front()));
                push_gap = $urandom_range(0, 3);
            end
            if (!push || taken)
            begin
                if (push_gap > 0)
                begin
                    push_gap  = push_gap - 1;
                    next_push = 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    op          <= pending_requests[0].op;
                    start_value <= pending_requests[0].start_v;
                    end_value   <= pending_requests[0].end_v;
                    progress    <= pending_requests[0].prog;
                    next_push   = 1'b1;
                end
                else
                    next_push = 1'b0;
            end
            push <= next_push;
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            pop       <= 1'b0;
            pop_stall <= 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected result %0d clip %0b", interpolated, clipped);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (interpolated !== want.value || clipped !== want.clip)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: expected %0d clip %0b, got %0d clip %0b",
                                     want.value, want.clip, interpolated, clipped);
                    end
                end
                pop_stall = $urandom_range(0, 3);
            end
            else if (pop_stall > 0)
                pop_stall = pop_stall - 1;
            pop <= (pop_stall == 0);
        end
    end

    task automatic add_request(logic [2:0] sel, logic signed [31:0] s, logic signed [31:0] e,
                               logic [16:0] t);
        request_t r;
        r.op      = sel;
        r.start_v = s;
        r.end_v   = e;
        r.prog    = t;
        pending_requests.push_back(r);
    endtask

    function automatic logic signed [31:0] draw_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $signed($urandom_range(0, 2000)) - 1000;
            2: v = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: v = $signed($urandom_range(0, 2000000)) - 1000000;
        endcase
        return v;
    endfunction

    task automatic add_random(int count);
        logic [16:0] t;
        for (int i = 0; i < count; i++)
        begin
            t = ($urandom_range(0, 9) < 7) ? 17'($urandom_range(0, eci_pkg::ONE))
                                           : 17'($urandom_range(0, 131071));
            add_request(3'($urandom_range(0, 7)), draw_value(), draw_value(), t);
        end
    endtask

    task automatic drain();
        while (pending_requests.size() > 0 || push || expected_outcomes.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic set_controls(longint y1, longint y2);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= eci_pkg::REG_BEZIER_FIRST_Y;
        cfg_data  <= y1[17:0];
        @(posedge clk);
        cfg_index <= eci_pkg::REG_BEZIER_SECOND_Y;
        cfg_data  <= y2[17:0];
        @(posedge clk);
        cfg_write     <= 1'b0;
        ctrl_first_y  = y1;
        ctrl_second_y = y2;
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        push          = 1'b0;
        pop           = 1'b0;
        op            = '0;
        start_value   = '0;
        end_value     = '0;
        progress      = '0;
        cfg_write     = 1'b0;
        cfg_index     = 1'b0;
        cfg_data      = '0;
        mismatches    = 0;
        ctrl_first_y  = 0;
        ctrl_second_y = eci_pkg::ONE;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // curve ends, midpoint, bounce segment edges, unused selectors, overlarge progress
        for (int s = 0; s < 6; s++)
        begin
            add_request(3'(s), 32'sh80000000, 32'sh7fffffff, 17'd0);
            add_request(3'(s), 32'sh7fffffff, 32'sh80000000, 17'(eci_pkg::ONE));
            add_request(3'(s), -32'sd5000, 32'sd70000, 17'd32767);
        end
        add_request(eci_pkg::OP_BOUNCE, 0, 32'sd1000000, 17'd23831);
        add_request(eci_pkg::OP_BOUNCE, 0, 32'sd1000000, 17'd23832);
        add_request(eci_pkg::OP_BOUNCE, 0, 32'sd1000000, 17'd47662);
        add_request(eci_pkg::OP_BOUNCE, 0, 32'sd1000000, 17'd59578);
        add_request(3'd6, 32'sd10, 32'sd1000, 17'd40000);
        add_request(3'd7, 32'sd10, 32'sd1000, 17'd131071);
        add_request(eci_pkg::OP_EASE_IN_OUT, 0, 32'sd65536, 17'd32768);
        drain();

        add_random(130);
        drain();
        set_controls(131071, -131072);
        add_request(eci_pkg::OP_BEZIER, 0, 32'sh7fffffff, 17'd16384);
        add_request(eci_pkg::OP_BEZIER, 32'sh7fffffff, 32'sh80000000, 17'd49152);
        add_random(130);
        drain();
        set_controls(-131072, 131071);
        add_random(130);
        drain();
        set_controls($signed($urandom_range(0, 262143)) - 131072,
                     $signed($urandom_range(0, 262143)) - 131072);
        add_random(130);
        drain();
        set_controls(0, 0);
        add_random(130);
        drain();

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
